>>> design/sse_pkg.sv
`default_nettype none

package sse_pkg;

	// input op codes
	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_END  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	// ASCII characters of the command syntax
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_S     = 8'h53;

	// register indexes of the configuration port
	localparam logic [1:0] REG_SETTLE = 2'd0;
	localparam logic [1:0] REG_FORCE  = 2'd1;
	localparam logic [1:0] REG_DEPLOY = 2'd2;

	// reset values and arithmetic constants
	localparam logic [23:0] SETTLE_RESET = 24'd1000000;
	localparam logic [15:0] FORCE_RESET  = 16'd20000;
	localparam logic [15:0] DEPLOY_RESET = 16'd1000;
	localparam logic [15:0] HP_RESET     = 16'd5000;
	// 16000 - (v - 1) * 3875 = 19875 - 3875 * v
	localparam logic signed [31:0] HP_BASE  = 32'sd19875;
	localparam logic signed [31:0] HP_SLOPE = 32'sd3875;
	localparam logic signed [31:0] HP_MIN   = 32'sd1;
	localparam logic signed [31:0] HP_MAX   = 32'sd65535;
	localparam logic [14:0] MAG_MAX = 15'd32767;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_END,
		KIND_TICK,
		KIND_NONE
	} kind_t;

	typedef enum logic [2:0] {
		LET_NONE,
		LET_X,
		LET_Y,
		LET_Z,
		LET_F,
		LET_D,
		LET_R,
		LET_S
	} letter_t;

	typedef enum logic [1:0] {
		MOT_DEPLOY = 2'd0,
		MOT_FORCE  = 2'd1,
		MOT_LENGTH = 2'd2
	} motor_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HIGH   = 4'b0010,
		PH_LOW    = 4'b0100,
		PH_SETTLE = 4'b1000
	} phase_t;

	// one classified request between front and back
	typedef struct packed {
		kind_t       kind;
		letter_t     letter;
		logic        is_eq;
		logic        is_minus;
		logic        is_digit;
		logic [3:0]  digit;
	} entry_t;

	typedef struct packed {
		logic [23:0] settle_ticks;
		logic [15:0] force_step_count;
		logic [15:0] deploy_step_count;
	} cfg_t;

endpackage

`default_nettype wire

>>> design/sse_front.sv
`default_nettype none

module sse_front (
	input  wire logic [1:0]     op,
	input  wire logic [7:0]     byte_value,
	output sse_pkg::entry_t     entry
);
	import sse_pkg::*;

	// classify the request and decode the byte once
	always_comb begin
		entry = '0;
		unique case (op)
			OP_BYTE: entry.kind = KIND_BYTE;
			OP_END:  entry.kind = KIND_END;
			OP_TICK: entry.kind = KIND_TICK;
			OP_NONE: entry.kind = KIND_NONE;
			default: entry.kind = KIND_NONE;
		endcase
		unique case (byte_value)
			CH_X:    entry.letter = LET_X;
			CH_Y:    entry.letter = LET_Y;
			CH_Z:    entry.letter = LET_Z;
			CH_F:    entry.letter = LET_F;
			CH_D:    entry.letter = LET_D;
			CH_R:    entry.letter = LET_R;
			CH_S:    entry.letter = LET_S;
			default: entry.letter = LET_NONE;
		endcase
		entry.is_eq    = (byte_value == CH_EQ);
		entry.is_minus = (byte_value == CH_MINUS);
		entry.is_digit = (byte_value >= CH_0) && (byte_value <= CH_9);
		entry.digit    = 4'(byte_value - CH_0);
	end

endmodule

`default_nettype wire

>>> design/sse_queue.sv
`default_nettype none

module sse_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sse_pkg::entry_t push_entry,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output sse_pkg::entry_t      head
);
	import sse_pkg::*;

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> design/sse_back.sv
`default_nettype none

module sse_back #(
	parameter int CMD_LEN = 20
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sse_pkg::cfg_t   cfg,
	input  wire logic            q_valid,
	input  wire sse_pkg::entry_t q_entry,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 step_deploy,
	output logic                 step_force,
	output logic                 step_length,
	output logic                 dir_deploy,
	output logic                 dir_force,
	output logic                 dir_length,
	output logic                 busy_res,
	output logic                 report_valid,
	output logic signed [15:0]   report_value
);
	import sse_pkg::*;

	localparam int CIW = $clog2(CMD_LEN + 1);

	// parser state
	logic [CIW-1:0]     char_index_q, char_index_n;
	letter_t            letter_q, letter_n;
	logic               saw_eq_q, saw_eq_n;
	logic               neg_q, neg_n;
	logic               stopped_q, stopped_n;
	logic [14:0]        mag_q, mag_n;
	logic signed [15:0] last_value_q, last_value_n;
	logic               last_dir_q, last_dir_n;
	// motion state
	logic [15:0]        half_period_q, half_period_n;
	phase_t             phase_q, phase_n;
	motor_t             motor_q, motor_n;
	logic [15:0]        steps_q, steps_n;
	logic [23:0]        tc_q, tc_n;
	logic [2:0]         dir_q, dir_n;

	logic               busy;
	logic [18:0]        mag_wide;
	logic               val_neg;
	logic [14:0]        val_mag;
	logic signed [15:0] value;
	logic [15:0]        value_abs;
	logic signed [31:0] hp_wide;
	logic               start;
	motor_t             st_motor;
	logic               st_dir;
	logic [15:0]        st_count;
	logic [23:0]        tc_inc;
	logic [15:0]        steps_dec;
	logic               rep_valid;
	logic signed [15:0] rep_value;
	logic               out_valid_q;

	assign busy    = (phase_q != PH_IDLE);
	assign q_pop   = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	// value of the command being closed, and the magnitude with the next digit appended
	always_comb begin
		mag_wide = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {15'b0, q_entry.digit};
		val_neg  = neg_q;
		val_mag  = mag_q;
		if (saw_eq_q) begin
			value = val_neg ? -$signed({1'b0, val_mag}) : $signed({1'b0, val_mag});
		end else begin
			value = last_value_q;
		end
		value_abs = value[15] ? 16'(-value) : 16'(value);
		hp_wide   = HP_BASE - HP_SLOPE * 32'(value);
	end

	// work out next state for the request at the queue head
	always_comb begin
		char_index_n  = char_index_q;
		letter_n      = letter_q;
		saw_eq_n      = saw_eq_q;
		neg_n         = neg_q;
		stopped_n     = stopped_q;
		mag_n         = mag_q;
		last_value_n  = last_value_q;
		last_dir_n    = last_dir_q;
		half_period_n = half_period_q;
		phase_n       = phase_q;
		motor_n       = motor_q;
		steps_n       = steps_q;
		tc_n          = tc_q;
		dir_n         = dir_q;
		start         = 1'b0;
		st_motor      = MOT_DEPLOY;
		st_dir        = 1'b0;
		st_count      = 16'd0;
		rep_valid     = 1'b0;
		rep_value     = 16'sd0;
		tc_inc        = tc_q + 24'd1;
		steps_dec     = (steps_q != 16'd0) ? steps_q - 16'd1 : steps_q;

		unique case (q_entry.kind)
			KIND_BYTE: begin
				if (!busy && char_index_q < CIW'(CMD_LEN)) begin
					char_index_n = char_index_q + CIW'(1);
					if (char_index_q == CIW'(0)) begin
						letter_n = q_entry.letter;
					end else if (char_index_q == CIW'(1)) begin
						saw_eq_n = q_entry.is_eq;
					end else if (saw_eq_q && !stopped_q) begin
						if (char_index_q == CIW'(2) && q_entry.is_minus) begin
							neg_n = 1'b1;
						end else if (q_entry.is_digit) begin
							mag_n = (mag_wide > {4'b0, MAG_MAX}) ? MAG_MAX : mag_wide[14:0];
						end else begin
							stopped_n = 1'b1;
						end
					end
				end
			end
			KIND_END: begin
				if (!busy) begin
					rep_valid = 1'b1;
					rep_value = value;
					if (saw_eq_q) begin
						last_value_n = value;
						last_dir_n   = !val_neg;
					end
					unique case (letter_q)
						LET_X: begin
							start = 1'b1; st_motor = MOT_DEPLOY;
							st_dir = last_dir_n; st_count = value_abs;
						end
						LET_Y: begin
							start = 1'b1; st_motor = MOT_FORCE;
							st_dir = last_dir_n; st_count = value_abs;
						end
						LET_Z: begin
							start = 1'b1; st_motor = MOT_LENGTH;
							st_dir = last_dir_n; st_count = value_abs;
						end
						LET_F: begin
							start = 1'b1; st_motor = MOT_FORCE;
							st_dir = last_dir_n; st_count = cfg.force_step_count;
						end
						LET_D: begin
							start = 1'b1; st_motor = MOT_DEPLOY;
							st_dir = 1'b1; st_count = cfg.deploy_step_count;
						end
						LET_R: begin
							start = 1'b1; st_motor = MOT_DEPLOY;
							st_dir = 1'b0; st_count = cfg.deploy_step_count;
						end
						LET_S: begin
							if (hp_wide < HP_MIN) begin
								half_period_n = 16'(HP_MIN);
							end else if (hp_wide > HP_MAX) begin
								half_period_n = 16'(HP_MAX);
							end else begin
								half_period_n = hp_wide[15:0];
							end
						end
						LET_NONE: begin
						end
						default: begin
						end
					endcase
					// clear the parser
					char_index_n = '0;
					letter_n     = LET_NONE;
					saw_eq_n     = 1'b0;
					neg_n        = 1'b0;
					stopped_n    = 1'b0;
					mag_n        = 15'd0;
				end
			end
			KIND_TICK: begin
				if (busy) begin
					tc_n = tc_inc;
					unique case (phase_q)
						PH_HIGH: begin
							if (tc_inc >= {8'b0, half_period_q}) begin
								phase_n = PH_LOW;
								tc_n    = 24'd0;
							end
						end
						PH_LOW: begin
							if (tc_inc >= {8'b0, half_period_q}) begin
								steps_n = steps_dec;
								tc_n    = 24'd0;
								if (steps_dec != 16'd0) begin
									phase_n = PH_HIGH;
								end else begin
									phase_n = (cfg.settle_ticks == 24'd0) ? PH_IDLE : PH_SETTLE;
								end
							end
						end
						PH_SETTLE: begin
							if (tc_inc >= cfg.settle_ticks) begin
								phase_n = PH_IDLE;
								tc_n    = 24'd0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			KIND_NONE: begin
			end
			default: begin
			end
		endcase

		// launch a motion
		if (start) begin
			motor_n  = st_motor;
			steps_n  = st_count;
			tc_n     = 24'd0;
			unique case (st_motor)
				MOT_DEPLOY: dir_n[0] = st_dir;
				MOT_FORCE:  dir_n[1] = st_dir;
				MOT_LENGTH: dir_n[2] = st_dir;
				default:    dir_n    = dir_q;
			endcase
			if (st_count != 16'd0) begin
				phase_n = PH_HIGH;
			end else begin
				phase_n = (cfg.settle_ticks == 24'd0) ? PH_IDLE : PH_SETTLE;
			end
		end
	end

	// update state on each request taken from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_index_q  <= '0;
			letter_q      <= LET_NONE;
			saw_eq_q      <= 1'b0;
			neg_q         <= 1'b0;
			stopped_q     <= 1'b0;
			mag_q         <= 15'd0;
			last_value_q  <= 16'sd0;
			last_dir_q    <= 1'b0;
			half_period_q <= HP_RESET;
			phase_q       <= PH_IDLE;
			motor_q       <= MOT_DEPLOY;
			steps_q       <= 16'd0;
			tc_q          <= 24'd0;
			dir_q         <= 3'b000;
			out_valid_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				char_index_q  <= char_index_n;
				letter_q      <= letter_n;
				saw_eq_q      <= saw_eq_n;
				neg_q         <= neg_n;
				stopped_q     <= stopped_n;
				mag_q         <= mag_n;
				last_value_q  <= last_value_n;
				last_dir_q    <= last_dir_n;
				half_period_q <= half_period_n;
				phase_q       <= phase_n;
				motor_q       <= motor_n;
				steps_q       <= steps_n;
				tc_q          <= tc_n;
				dir_q         <= dir_n;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (q_pop) begin
			step_deploy  <= (phase_n == PH_HIGH) && (motor_n == MOT_DEPLOY);
			step_force   <= (phase_n == PH_HIGH) && (motor_n == MOT_FORCE);
			step_length  <= (phase_n == PH_HIGH) && (motor_n == MOT_LENGTH);
			dir_deploy   <= dir_n[0];
			dir_force    <= dir_n[1];
			dir_length   <= dir_n[2];
			busy_res     <= (phase_n != PH_IDLE);
			report_valid <= rep_valid;
			report_value <= rep_value;
		end
	end

endmodule

`default_nettype wire

>>> design/serial_stepper_command_executor.sv
// Serial stepper command executor.
// Input channel (in_valid / in_stall): one request per accepted item, op selects
// a command byte, an end-of-command mark, a 1 us tick or no operation; byte_value carries the byte.
// Output channel (out_valid / out_stall): exactly one result per request, in order,
// with the step and direction line levels, busy_res and the command report.
// Requests are classified on entry and pass through a two-entry queue to the
// executor, which updates the parser and motion counters once per request.
// Each accepted request is written into the queue; its result is registered in the
// output register when the executor takes the request from the queue head.
// Throughput: one request per cycle while out_stall is low, set by the single executor
// update per request; the queue and the output register keep it at one per cycle.
// When out_stall is high the result holds, the executor pauses and the queue
// fills; in_stall rises once both queue entries are taken.
// APB port: settle_ticks at 0x0, force_step_count at 0x4, deploy_step_count at 0x8;
// write only while idle. Reset clears the parser, stops all motion, sets the
// half period to 5000 ticks and restores the register defaults.
`default_nettype none

module serial_stepper_command_executor #(
	parameter int CMD_LEN = 20
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         op,
	input  wire logic [7:0]         byte_value,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    step_deploy,
	output logic                    step_force,
	output logic                    step_length,
	output logic                    dir_deploy,
	output logic                    dir_force,
	output logic                    dir_length,
	output logic                    busy_res,
	output logic                    report_valid,
	output logic signed [15:0]      report_value
);
	import sse_pkg::*;

	cfg_t   cfg_q;
	entry_t front_entry;
	entry_t head_entry;
	logic   q_full;
	logic   q_not_empty;
	logic   q_pop;
	logic   push;
	logic   cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks      <= SETTLE_RESET;
			cfg_q.force_step_count  <= FORCE_RESET;
			cfg_q.deploy_step_count <= DEPLOY_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SETTLE: cfg_q.settle_ticks      <= pwdata[23:0];
				REG_FORCE:  cfg_q.force_step_count  <= pwdata[15:0];
				REG_DEPLOY: cfg_q.deploy_step_count <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// read back configuration registers
	always_comb begin
		unique case (paddr[3:2])
			REG_SETTLE: prdata = {8'b0, cfg_q.settle_ticks};
			REG_FORCE:  prdata = {16'b0, cfg_q.force_step_count};
			REG_DEPLOY: prdata = {16'b0, cfg_q.deploy_step_count};
			default:    prdata = 32'b0;
		endcase
	end

	sse_front u_front (
		.op         (op),
		.byte_value (byte_value),
		.entry      (front_entry)
	);

	sse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (head_entry)
	);

	sse_back #(
		.CMD_LEN (CMD_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_not_empty),
		.q_entry      (head_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_deploy  (step_deploy),
		.step_force   (step_force),
		.step_length  (step_length),
		.dir_deploy   (dir_deploy),
		.dir_force    (dir_force),
		.dir_length   (dir_length),
		.busy_res     (busy_res),
		.report_valid (report_valid),
		.report_value (report_value)
	);

	// only one motor steps at a time
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({step_deploy, step_force, step_length}) <= 1)
		else $error("more than one step line high");

	// a high step line means motion is in progress
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (step_deploy || step_force || step_length) |-> busy_res)
		else $error("step line high while not busy");

	// without a report the report value is zero
	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !report_valid |-> report_value == 16'sd0)
		else $error("report value without report");

endmodule

`default_nettype wire

>>> sim/tb_serial_stepper_command_executor.sv
`timescale 1ns / 100ps

module tb_serial_stepper_command_executor;
	import sse_pkg::*;

	localparam int CMD_LEN = 20;

	typedef struct packed {
		logic               step_deploy;
		logic               step_force;
		logic               step_length;
		logic               dir_deploy;
		logic               dir_force;
		logic               dir_length;
		logic               busy_res;
		logic               report_valid;
		logic signed [15:0] report_value;
	} lines_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         op;
	logic [7:0]         byte_value;
	logic               out_valid;
	logic               out_stall;
	logic               step_deploy;
	logic               step_force;
	logic               step_length;
	logic               dir_deploy;
	logic               dir_force;
	logic               dir_length;
	logic               busy_res;
	logic               report_valid;
	logic signed [15:0] report_value;

	serial_stepper_command_executor #(
		.CMD_LEN(CMD_LEN)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.byte_value   (byte_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_deploy  (step_deploy),
		.step_force   (step_force),
		.step_length  (step_length),
		.dir_deploy   (dir_deploy),
		.dir_force    (dir_force),
		.dir_length   (dir_length),
		.busy_res     (busy_res),
		.report_valid (report_valid),
		.report_value (report_value)
	);

	// predicted copy of the configuration
	logic [23:0]        cfg_settle;
	logic [15:0]        cfg_force;
	logic [15:0]        cfg_deploy;

	// predicted parser state
	int unsigned        cmd_pos;
	logic [7:0]         cmd_letter;
	bit                 has_eq;
	bit                 neg_val;
	bit                 num_done;
	logic [14:0]        mag;
	logic signed [15:0] held_value;
	bit                 held_dir;

	// predicted motion state
	logic [15:0]        half_per;
	phase_t             phase;
	motor_t             act_motor;
	logic [15:0]        steps_todo;
	logic [23:0]        tick_cnt;
	logic [2:0]         dirs;

	lines_t             expected_lines[$];
	logic [7:0]         cmd_text[$];
	int                 fail_count;
	int                 sent_items;
	int                 busy_noise;
	bit                 idle_en;
	int                 stall_left;

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (!idle_en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic flag_failure(input string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	// ---------------------------------------------------------------- predictor

	task automatic clear_parser();
		cmd_pos = 0;
		cmd_letter = 8'h00;
		has_eq = 1'b0;
		neg_val = 1'b0;
		num_done = 1'b0;
		mag = '0;
	endtask

	task automatic model_reset();
		cfg_settle = SETTLE_RESET;
		cfg_force = FORCE_RESET;
		cfg_deploy = DEPLOY_RESET;
		clear_parser();
		held_value = '0;
		held_dir = 1'b0;
		half_per = HP_RESET;
		phase = PH_IDLE;
		act_motor = MOT_DEPLOY;
		steps_todo = '0;
		tick_cnt = '0;
		dirs = '0;
	endtask

	task automatic enter_dwell();
		tick_cnt = '0;
		phase = (cfg_settle == 24'd0) ? PH_IDLE : PH_SETTLE;
	endtask

	task automatic start_motor(input motor_t m, input logic d, input logic [15:0] count);
		act_motor = m;
		dirs[m] = d;
		steps_todo = count;
		tick_cnt = '0;
		if (count != 16'd0)
			phase = PH_HIGH;
		else
			enter_dwell();
	endtask

	task automatic collect_byte(input logic [7:0] b);
		int unsigned m;
		if (cmd_pos >= CMD_LEN)
			return;
		cmd_pos++;
		if (cmd_pos == 1) begin
			cmd_letter = b;
		end else if (cmd_pos == 2) begin
			has_eq = (b == CH_EQ);
		end else if (has_eq && !num_done) begin
			if (cmd_pos == 3 && b == CH_MINUS) begin
				neg_val = 1'b1;
			end else if (b >= CH_0 && b <= CH_9) begin
				// saturate the magnitude
				m = mag * 10 + (b - CH_0);
				mag = (m > MAG_MAX) ? MAG_MAX : m[14:0];
			end else begin
				num_done = 1'b1;
			end
		end
	endtask

	task automatic execute_command(output logic signed [15:0] v);
		logic [15:0] cnt;
		int          hp;
		// without '=' the previous value and direction stand
		if (has_eq) begin
			held_value = neg_val ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			held_dir = !neg_val;
		end
		v = held_value;
		cnt = (v < 0) ? -v : v;
		case (cmd_letter)
			CH_X: start_motor(MOT_DEPLOY, held_dir, cnt);
			CH_Y: start_motor(MOT_FORCE, held_dir, cnt);
			CH_Z: start_motor(MOT_LENGTH, held_dir, cnt);
			CH_F: start_motor(MOT_FORCE, held_dir, cfg_force);
			CH_D: start_motor(MOT_DEPLOY, 1'b1, cfg_deploy);
			CH_R: start_motor(MOT_DEPLOY, 1'b0, cfg_deploy);
			CH_S: begin
				hp = 16000 - (int'(v) - 1) * 3875;
				if (hp < 1)
					hp = 1;
				if (hp > 65535)
					hp = 65535;
				half_per = hp[15:0];
			end
			default: ;
		endcase
		clear_parser();
	endtask

	task automatic count_tick();
		if (phase == PH_IDLE)
			return;
		tick_cnt = tick_cnt + 24'd1;
		case (phase)
			PH_HIGH: begin
				if (tick_cnt >= half_per) begin
					phase = PH_LOW;
					tick_cnt = '0;
				end
			end
			PH_LOW: begin
				if (tick_cnt >= half_per) begin
					if (steps_todo != 16'd0)
						steps_todo = steps_todo - 16'd1;
					tick_cnt = '0;
					if (steps_todo != 16'd0)
						phase = PH_HIGH;
					else
						enter_dwell();
				end
			end
			default: begin
				if (tick_cnt >= cfg_settle) begin
					phase = PH_IDLE;
					tick_cnt = '0;
				end
			end
		endcase
	endtask

	task automatic predict_lines(input logic [1:0] kind, input logic [7:0] b, output lines_t r);
		bit                 was_busy;
		logic signed [15:0] v;
		was_busy = (phase != PH_IDLE);
		r = '0;
		case (kind)
			OP_BYTE: if (!was_busy) collect_byte(b);
			OP_END: begin
				if (!was_busy) begin
					execute_command(v);
					r.report_valid = 1'b1;
					r.report_value = v;
				end
			end
			OP_TICK: count_tick();
			default: ;
		endcase
		r.step_deploy = (phase == PH_HIGH) && (act_motor == MOT_DEPLOY);
		r.step_force = (phase == PH_HIGH) && (act_motor == MOT_FORCE);
		r.step_length = (phase == PH_HIGH) && (act_motor == MOT_LENGTH);
		r.dir_deploy = dirs[0];
		r.dir_force = dirs[1];
		r.dir_length = dirs[2];
		r.busy_res = (phase != PH_IDLE);
	endtask

	// ---------------------------------------------------------------- drivers

	// drive one request and hold it until accepted
	task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
		lines_t want;
		int     gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		op <= kind;
		byte_value <= b;
		sent_items++;
		predict_lines(kind, b, want);
		expected_lines.push_back(want);
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// tick until the motion and the dwell are over, with dropped requests mixed in
	task automatic run_until_idle();
		while (phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < busy_noise)
				send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			else
				send_item(OP_TICK, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic issue_text();
		foreach (cmd_text[i])
			send_item(OP_BYTE, cmd_text[i]);
		send_item(OP_END, 8'($urandom_range(0, 255)));
		run_until_idle();
	endtask

	task automatic append_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			cmd_text.push_back(s[i]);
	endtask

	task automatic say(input string s);
		cmd_text.delete();
		append_text(s);
		issue_text();
	endtask

	// stop sending and wait until every result is back
	task automatic wait_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write a register, then read it back
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_SETTLE: cfg_settle = val[23:0];
			REG_FORCE:  cfg_force = val[15:0];
			REG_DEPLOY: cfg_deploy = val[15:0];
			default: ;
		endcase
		if (rd !== val)
			flag_failure($sformatf("register %0d read %h, expected %h", idx, rd, val));
	endtask

	// stall the result side in bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		lines_t want;
		lines_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {step_deploy, step_force, step_length, dir_deploy, dir_force, dir_length,
				busy_res, report_valid, report_value};
			if (expected_lines.size() == 0) begin
				flag_failure($sformatf("%0t: result with nothing expected", $realtime));
			end else begin
				want = expected_lines.pop_front();
				if (got !== want)
					flag_failure({
						$sformatf("%0t: step %b%b%b dir %b%b%b busy %b report %b %0d",
							$realtime, got.step_deploy, got.step_force,
							got.step_length, got.dir_deploy, got.dir_force,
							got.dir_length, got.busy_res, got.report_valid,
							$signed(got.report_value)),
						$sformatf(", expected step %b%b%b dir %b%b%b busy %b report %b %0d",
							want.step_deploy, want.step_force, want.step_length,
							want.dir_deploy, want.dir_force, want.dir_length,
							want.busy_res, want.report_valid,
							$signed(want.report_value))});
			end
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_register_access();
		write_reg(REG_SETTLE, 32'd16777215);
		write_reg(REG_FORCE, 32'd0);
		write_reg(REG_DEPLOY, 32'd65535);
		write_reg(REG_SETTLE, 32'd0);
		write_reg(REG_FORCE, 32'd65535);
		write_reg(REG_DEPLOY, 32'd0);
		write_reg(REG_SETTLE, 32'd3);
		write_reg(REG_FORCE, 32'd2);
		write_reg(REG_DEPLOY, 32'd3);
	endtask

	// speed levels: saturated magnitudes clamp to both ends, no '=' reuses
	task automatic test_speed_setting();
		say("S=99999");
		say("S=-99999");
		say("S=0");
		say("S=5");
		say("S");
		say("S=6");
	endtask

	task automatic test_motion_commands();
		say("X=3");
		say("Y=-2");
		say("Z=1");
		say("F");
		say("F=-4");
		say("D");
		say("R");
		say("X");
		// negative zero: no steps, direction cleared
		say("Z=-0");
		say("Y=0");
	endtask

	task automatic test_slow_stepping();
		say("S=5");
		say("Y=1");
		say("S=6");
	endtask

	task automatic test_parser_cases();
		say("");
		say("Q=7");
		say("X=12a34");
		say("X=-");
		say("X5");
		say("X=1-2");
		say("X==3");
		say("X=00002");
		// bytes past the command length are ignored
		say({"Z=", {18{"0"}}, "9"});
	endtask

	task automatic test_busy_drop();
		busy_noise = 60;
		say("Z=5");
		say("R");
		busy_noise = 10;
	endtask

	task automatic test_zero_dwell();
		wait_until_drained();
		write_reg(REG_SETTLE, 32'd0);
		say("X=2");
		say("X=0");
		say("D");
	endtask

	task automatic test_idle_ticks();
		send_item(OP_TICK, 8'hFF);
		send_item(OP_NONE, 8'h00);
		send_item(OP_NONE, CH_X);
		send_item(OP_TICK, 8'h00);
	endtask

	// force motor run with no gaps on either side
	task automatic test_back_to_back_run();
		wait_until_drained();
		write_reg(REG_FORCE, 32'd12);
		write_reg(REG_SETTLE, 32'd2);
		idle_en = 1'b0;
		busy_noise = 0;
		say("F=1");
		idle_en = 1'b1;
		busy_noise = 10;
	endtask

	task automatic random_config();
		wait_until_drained();
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SETTLE, $urandom_range(20, 40));
		else
			write_reg(REG_SETTLE, $urandom_range(0, 6));
		write_reg(REG_FORCE, $urandom_range(0, 4));
		write_reg(REG_DEPLOY, $urandom_range(0, 4));
	endtask

	task automatic random_command();
		int         pick;
		int         n;
		logic [7:0] ch;
		cmd_text.delete();
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			// noise: random bytes, possibly longer than a command
			n = $urandom_range(0, 24);
			repeat (n) cmd_text.push_back(8'($urandom));
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				case ($urandom_range(0, 2))
					0: ch = CH_X;
					1: ch = CH_Y;
					default: ch = CH_Z;
				endcase
			end else if (pick < 50) begin
				ch = CH_F;
			end else if (pick < 65) begin
				ch = ($urandom_range(0, 1) != 0) ? CH_D : CH_R;
			end else if (pick < 80) begin
				ch = CH_S;
			end else begin
				ch = 8'($urandom);
			end
			// an empty command sends no bytes at all
			if (pick < 95) begin
				cmd_text.push_back(ch);
				if ($urandom_range(0, 99) < 85)
					cmd_text.push_back(CH_EQ);
				if ($urandom_range(0, 99) < 30)
					cmd_text.push_back(CH_MINUS);
				if ($urandom_range(0, 9) == 0)
					cmd_text.push_back(CH_0);
				if ($urandom_range(0, 9) != 0) begin
					if (ch == CH_X || ch == CH_Y || ch == CH_Z)
						n = $urandom_range(0, 20);
					else if ($urandom_range(0, 99) < 70)
						n = $urandom_range(0, 99);
					else
						n = $urandom_range(0, 999999);
					append_text($sformatf("%0d", n));
				end
				if ($urandom_range(0, 99) < 15) begin
					cmd_text.push_back(8'($urandom));
					append_text($sformatf("%0d", $urandom_range(0, 9)));
				end
			end
		end
		issue_text();
		// keep the speed fast and the reused value small
		if (half_per != 16'd1 || held_value > 20 || held_value < -20)
			say("S=7");
	endtask

	task automatic test_random_commands();
		int start_items;
		int cmds;
		start_items = sent_items;
		cmds = 0;
		random_config();
		while (sent_items < start_items + 500) begin
			idle_en = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 8) begin
				repeat ($urandom_range(1, 3))
					send_item(($urandom_range(0, 1) != 0) ? OP_TICK : OP_NONE,
						8'($urandom));
			end
			random_command();
			cmds++;
			if (cmds % 25 == 0)
				random_config();
		end
		idle_en = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		op = OP_NONE;
		byte_value = '0;
		out_stall = 1'b0;
		stall_left = 0;
		fail_count = 0;
		sent_items = 0;
		busy_noise = 10;
		idle_en = 1'b1;
		model_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_access();
		test_speed_setting();
		test_motion_commands();
		test_slow_stepping();
		test_parser_cases();
		test_busy_drop();
		test_idle_ticks();
		test_zero_dwell();
		test_back_to_back_run();
		test_random_commands();

		wait_until_drained();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// give up on a hung run
	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
design/sse_pkg.sv
design/sse_front.sv
design/sse_queue.sv
design/sse_back.sv
design/serial_stepper_command_executor.sv
sim/tb_serial_stepper_command_executor.sv
